>>> rtl/qdpi_pkg.sv
// ----------------------------------------------------------------------------
// qdpi_pkg: shared types and constants for the quadrature decoder / PI loop
// Item kinds, sequencer states, register indexes and the edge decode helper.
// ----------------------------------------------------------------------------
package qdpi_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int MAX_W      = 16;  // width of the tick maximum registers
  localparam int GAIN_W     = 16;
  localparam int FAULT_W    = 16;
  localparam int TARGET_W   = 10;
  localparam int ANGLE_W    = 9;
  localparam int DRIVE_W    = 9;
  localparam int SUM_W      = 8;
  localparam int ERR_W      = 11;  // target minus angle before wrapping
  localparam int QUOT_W     = 9;   // quotient below 360 when gear < max
  localparam int DIVIDEND_W = 25;  // 16 bit gear count times 360
  localparam int MUL_W      = 17;  // signed operand width of shared multiplier
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [MAX_W-1:0] MOTOR_MAX_RST = 16'd2015;
  localparam logic [MAX_W-1:0] GEAR_MAX_RST  = 16'd8063;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd10;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;

  localparam int FULL_TURN  = 360;
  localparam int HALF_TURN  = 180;
  localparam int SUM_LIMIT  = 100;
  localparam int DRIVE_LIMIT = 150;

  typedef enum logic [1:0] {
    KIND_EDGE_A = 2'd0,
    KIND_EDGE_B = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_START  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MOTOR_MAX  = 2'd0,
    REG_GEAR_MAX   = 2'd1,
    REG_PROP_GAIN  = 2'd2,
    REG_INTEG_GAIN = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_CLEAR,
    S_ANGLE,
    S_MULA,
    S_DIVGO,
    S_DIVW,
    S_ERR,
    S_WRAP,
    S_SUM,
    S_MULP,
    S_MULI,
    S_SAT,
    S_RESULT
  } state_t;

  // Decode one pin edge against the last A/B levels.
  function automatic dir_t edge_dir(logic pin_b, logic lvl, logic la, logic lb);
    dir_t d;
    d = DIR_NONE;
    if (!pin_b) begin
      if (lvl) begin
        if (!la && lb) d = DIR_UP;
        else if (!la && !lb) d = DIR_DOWN;
      end else begin
        if (la && !lb) d = DIR_UP;
        else if (la && lb) d = DIR_DOWN;
      end
    end else begin
      if (lvl) begin
        if (!la && !lb) d = DIR_UP;
        else if (la && !lb) d = DIR_DOWN;
      end else begin
        if (la && lb) d = DIR_UP;
        else if (!la && lb) d = DIR_DOWN;
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/qdpi_div.sv
// ----------------------------------------------------------------------------
// qdpi_div: restoring divider for the gear angle
// One quotient bit per cycle; caller guarantees quotient < 512.
// ----------------------------------------------------------------------------
module qdpi_div
  import qdpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [MAX_W-1:0]      divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quot
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dsh;
  logic                  fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath: divisor starts aligned to the top quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= DIVIDEND_W'({divisor, {(QUOT_W-1){1'b0}}});
      quot <= '0;
    end else if (busy) begin
      if (fits) rem <= rem - dsh;
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

>>> rtl/quadrature_decoder_pi_position_loop_top.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_pi_position_loop_top: encoder decoder with PI position loop
// Sequence: edge and start beats pass one update state before the result
//   state; a control tick runs the gear*360 pass and the divider when the
//   angle needs it, up to two error wrap steps and the kp and ki passes.
// Throughput: one input beat at a time; in_ready is high only when idle.
// Reset (rst, synchronous, active high) clears counters, levels, error sum,
//   drive and output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module quadrature_decoder_pi_position_loop_top
  import qdpi_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [MAX_W-1:0]           cfg_data,
  // input beat
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic                       pin_level,
  input  logic signed [TARGET_W-1:0] target_degrees,
  // result beat
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                motor_count,
  output logic [15:0]                gear_count,
  output logic [FAULT_W-1:0]         fault_count,
  output logic [ANGLE_W-1:0]         gear_angle,
  output logic signed [DRIVE_W-1:0]  drive
);

  // gear count compared against the 16 bit maximum in a common width
  localparam int WIDE_W = (COUNT_WIDTH > MAX_W) ? COUNT_WIDTH : MAX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAX_W-1:0]         motor_max;
  logic [MAX_W-1:0]         gear_max;
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_max  <= MOTOR_MAX_RST;
      gear_max   <= GEAR_MAX_RST;
      prop_gain  <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MOTOR_MAX:  motor_max  <= cfg_data;
        REG_GEAR_MAX:   gear_max   <= cfg_data;
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Wrapping counters. The maximum is cut or extended to the counter width.
  // --------------------------------------------------------------------------
  function automatic logic [COUNT_WIDTH-1:0] count_up(
    logic [COUNT_WIDTH-1:0] c, logic [MAX_W-1:0] mx);
    logic [COUNT_WIDTH-1:0] r;
    if (c == COUNT_WIDTH'(mx)) r = '0;
    else r = c + 1'b1;
    return r;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] count_down(
    logic [COUNT_WIDTH-1:0] c, logic [MAX_W-1:0] mx);
    logic [COUNT_WIDTH-1:0] r;
    if (c == '0) r = COUNT_WIDTH'(mx);
    else r = c - 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state, state_next;

  // latched input beat
  kind_t                     kind_q;
  logic                      lvl_q;
  logic signed [TARGET_W-1:0] target_q;

  // decoder and loop state
  logic                      last_a, last_b;
  logic [COUNT_WIDTH-1:0]    motor_ticks, gear_ticks;
  logic [FAULT_W-1:0]        bad_edges;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [DRIVE_W-1:0] last_drive;

  // working registers
  logic [ANGLE_W-1:0]        angle;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  prod;

  logic [WIDE_W-1:0]         gear_w;
  logic                      gear_at_max;
  logic                      err_high, err_low;
  dir_t                      dir;

  // sequencer outputs
  logic in_take;
  logic div_start;
  logic out_load;

  // divider link
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign gear_w      = WIDE_W'(gear_ticks);
  assign gear_at_max = (gear_w >= WIDE_W'(gear_max));
  assign err_high    = (err > ERR_W'(HALF_TURN));
  assign err_low     = (err < -ERR_W'(HALF_TURN));
  assign dir         = edge_dir(kind_q == KIND_EDGE_B, lvl_q, last_a, last_b);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_EDGE_A, KIND_EDGE_B: state_next = S_EDGE;
            KIND_TICK:                state_next = S_ANGLE;
            KIND_START:               state_next = S_CLEAR;
            default:                  state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE:  state_next = S_RESULT;
      S_CLEAR: state_next = S_RESULT;
      S_ANGLE: begin
        // zero maximum gives angle 0; a count at or past the maximum saturates
        if (gear_max == '0 || gear_at_max) state_next = S_ERR;
        else state_next = S_MULA;
      end
      S_MULA:  state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIVW;
      S_DIVW:  if (div_done) state_next = S_ERR;
      S_ERR:   state_next = S_WRAP;
      S_WRAP:  if (!err_high && !err_low) state_next = S_SUM;
      S_SUM:   state_next = S_MULP;
      S_MULP:  state_next = S_MULI;
      S_MULI:  state_next = S_SAT;
      S_SAT:   state_next = S_RESULT;
      S_RESULT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE:   in_ready  = 1'b1;
      S_DIVGO:  div_start = 1'b1;
      S_RESULT: out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // --------------------------------------------------------------------------
  // Shared signed multiplier; operands picked by the sequencer step.
  // gear*360 for the angle, then err*kp, then sum*ki.
  // --------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (state)
      S_MULA: begin
        mul_a = MUL_W'({1'b0, gear_w[MAX_W-1:0]});
        mul_b = MUL_W'(FULL_TURN);
      end
      S_MULP: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'(prop_gain);
      end
      S_MULI: begin
        mul_a = MUL_W'(error_sum);
        mul_b = MUL_W'(integ_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  qdpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIVIDEND_W-1:0]),
    .divisor  (gear_max),
    .done     (div_done),
    .quot     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Control state updates
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0] sum_wide;
  assign sum_wide = ERR_W'(error_sum) + err;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_a      <= 1'b0;
      last_b      <= 1'b0;
      motor_ticks <= '0;
      gear_ticks  <= '0;
      bad_edges   <= '0;
      error_sum   <= '0;
      last_drive  <= '0;
    end else begin
      case (state)
        S_EDGE: begin
          case (dir)
            DIR_UP: begin
              motor_ticks <= count_up(motor_ticks, motor_max);
              gear_ticks  <= count_up(gear_ticks, gear_max);
            end
            DIR_DOWN: begin
              motor_ticks <= count_down(motor_ticks, motor_max);
              gear_ticks  <= count_down(gear_ticks, gear_max);
            end
            default: bad_edges <= bad_edges + 1'b1;
          endcase
          // the stored pin level follows even on an invalid transition
          if (kind_q == KIND_EDGE_B) last_b <= lvl_q;
          else last_a <= lvl_q;
        end
        S_CLEAR: error_sum <= '0;
        S_SUM: begin
          if (sum_wide > ERR_W'(SUM_LIMIT)) error_sum <= SUM_W'(SUM_LIMIT);
          else if (sum_wide < -ERR_W'(SUM_LIMIT)) error_sum <= -SUM_W'(SUM_LIMIT);
          else error_sum <= SUM_W'(sum_wide);
        end
        S_SAT: begin
          if (prod > PROD_W'(DRIVE_LIMIT)) last_drive <= DRIVE_W'(DRIVE_LIMIT);
          else if (prod < -PROD_W'(DRIVE_LIMIT)) last_drive <= -DRIVE_W'(DRIVE_LIMIT);
          else last_drive <= DRIVE_W'(prod);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q   <= kind_t'(kind);
      lvl_q    <= pin_level;
      target_q <= target_degrees;
      angle    <= '0;   // edge and start beats report angle 0
    end
    case (state)
      S_ANGLE: begin
        if (gear_max != '0 && gear_at_max) angle <= ANGLE_W'(FULL_TURN);
      end
      S_MULA: prod <= mul_p;
      S_DIVW: if (div_done) angle <= div_quot;
      S_ERR:  err  <= ERR_W'(target_q) - ERR_W'({1'b0, angle});
      S_WRAP: begin
        if (err_high) err <= err - ERR_W'(FULL_TURN);
        else if (err_low) err <= err + ERR_W'(FULL_TURN);
      end
      S_MULP: prod <= mul_p;
      S_MULI: prod <= prod + mul_p;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: holds the result beat until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      motor_count <= 16'(motor_ticks);
      gear_count  <= 16'(gear_ticks);
      fault_count <= bad_edges;
      gear_angle  <= angle;
      drive       <= last_drive;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (error_sum <= SUM_W'(SUM_LIMIT)) && (error_sum >= -SUM_W'(SUM_LIMIT)))
    else $error("error sum left its clamp range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (last_drive <= DRIVE_W'(DRIVE_LIMIT)) && (last_drive >= -DRIVE_W'(DRIVE_LIMIT)))
    else $error("drive left its saturation range");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider finished outside its wait step");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gear_angle <= ANGLE_W'(FULL_TURN)))
    else $error("reported angle above a full turn");

endmodule

>>> verif/quadrature_decoder_pi_position_loop_top_tb.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_pi_position_loop_top_tb: self-checking bench
// Drives encoder edges, control ticks and start beats through the valid/ready
// input channel and checks every result beat against an in-bench model of
// the decoder and the PI loop. Register settings change between phases while
// the block is idle. Both channels idle at random, and the sink parks once.
// ----------------------------------------------------------------------------
module quadrature_decoder_pi_position_loop_top_tb;
  import qdpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles with work outstanding and no beat on either side.
  localparam int STALL_LIMIT = 3000;
  localparam int PARK_CYCLES = 250;
  localparam int TAIL_CYCLES = 30;

  typedef struct {
    kind_t             kind;
    logic              lvl;
    logic signed [9:0] tgt;
  } enc_item_t;

  typedef struct {
    logic [15:0]       motor;
    logic [15:0]       gear;
    logic [15:0]       faults;
    logic [8:0]        angle;
    logic signed [8:0] drv;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [MAX_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 kind = '0;
  logic                       pin_level = 1'b0;
  logic signed [TARGET_W-1:0] target_degrees = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [15:0]                motor_count;
  logic [15:0]                gear_count;
  logic [FAULT_W-1:0]         fault_count;
  logic [ANGLE_W-1:0]         gear_angle;
  logic signed [DRIVE_W-1:0]  drive;

  quadrature_decoder_pi_position_loop_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .pin_level      (pin_level),
    .target_degrees (target_degrees),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_count    (motor_count),
    .gear_count     (gear_count),
    .fault_count    (fault_count),
    .gear_angle     (gear_angle),
    .drive          (drive)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Position / loop model. Register copies and state start at reset values.
  // --------------------------------------------------------------------------
  logic [15:0]        motor_top = MOTOR_MAX_RST;
  logic [15:0]        gear_top  = GEAR_MAX_RST;
  logic signed [15:0] kp_m      = PROP_GAIN_RST;
  logic signed [15:0] ki_m      = INTEG_GAIN_RST;

  logic        enc_a = 1'b0;
  logic        enc_b = 1'b0;
  logic [15:0] motor_pos = '0;
  logic [15:0] gear_pos  = '0;
  logic [15:0] bad_edge_cnt = '0;
  int          integ_sum = 0;
  int          drive_now = 0;

  // One quadrature step on both counters; step 0 is a bad transition.
  function automatic void move_shaft(int step);
    if (step > 0) begin
      motor_pos = (motor_pos == motor_top) ? 16'd0 : motor_pos + 16'd1;
      gear_pos  = (gear_pos == gear_top) ? 16'd0 : gear_pos + 16'd1;
    end else if (step < 0) begin
      motor_pos = (motor_pos == 16'd0) ? motor_top : motor_pos - 16'd1;
      gear_pos  = (gear_pos == 16'd0) ? gear_top : gear_pos - 16'd1;
    end else begin
      bad_edge_cnt = bad_edge_cnt + 16'd1;
    end
  endfunction

  function automatic reading_t next_reading(kind_t k, logic lvl, logic signed [9:0] tgt);
    reading_t r;
    int step;
    int ang;
    int gp;
    int gt;
    int err;
    int drv;
    int kp;
    int ki;
    ang = 0;
    case (k)
      KIND_EDGE_A: begin
        if (lvl) step = (!enc_a && enc_b) ? 1 : ((!enc_a && !enc_b) ? -1 : 0);
        else step = (enc_a && !enc_b) ? 1 : ((enc_a && enc_b) ? -1 : 0);
        move_shaft(step);
        enc_a = lvl;
      end
      KIND_EDGE_B: begin
        if (lvl) step = (!enc_a && !enc_b) ? 1 : ((enc_a && !enc_b) ? -1 : 0);
        else step = (enc_a && enc_b) ? 1 : ((!enc_a && enc_b) ? -1 : 0);
        move_shaft(step);
        enc_b = lvl;
      end
      KIND_TICK: begin
        gp = gear_pos;
        gt = gear_top;
        if (gt != 0) ang = (gp * FULL_TURN) / gt;
        if (ang > FULL_TURN) ang = FULL_TURN;
        err = tgt;
        err = err - ang;
        while (err > HALF_TURN) err = err - FULL_TURN;
        while (err < -HALF_TURN) err = err + FULL_TURN;
        integ_sum = integ_sum + err;
        if (integ_sum > SUM_LIMIT) integ_sum = SUM_LIMIT;
        else if (integ_sum < -SUM_LIMIT) integ_sum = -SUM_LIMIT;
        kp = kp_m;
        ki = ki_m;
        drv = err * kp + integ_sum * ki;
        if (drv > DRIVE_LIMIT) drv = DRIVE_LIMIT;
        else if (drv < -DRIVE_LIMIT) drv = -DRIVE_LIMIT;
        drive_now = drv;
      end
      default: begin
        integ_sum = 0;
      end
    endcase
    r.motor  = motor_pos;
    r.gear   = gear_pos;
    r.faults = bad_edge_cnt;
    r.angle  = ang[8:0];
    r.drv    = drive_now[8:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus queue and bookkeeping shared by the driver, sink and checker.
  // --------------------------------------------------------------------------
  enc_item_t   pending_beats[$];
  reading_t    readings_due[$];
  int unsigned beats_offered = 0;  // popped by the driver
  int unsigned results_seen  = 0;
  int unsigned fails = 0;

  logic beat_taken = 1'b0;  // set at the accepting edge, consumed at the next fall
  int   send_gap   = 0;
  int   sink_hold  = 0;
  logic park_sink  = 1'b0;  // one long sink hold-off on request
  logic quiet      = 1'b0;  // no idling on either side

  // Mirror of the pin levels as queued, so generated steps stay in sequence.
  logic gen_a = 1'b0;
  logic gen_b = 1'b0;
  int   run_dir  = 1;
  int   run_left = 0;

  task automatic queue_item(kind_t k, logic lvl, int tgt);
    enc_item_t it;
    it.kind = k;
    it.lvl  = lvl;
    it.tgt  = tgt[9:0];
    pending_beats.push_back(it);
    if (k == KIND_EDGE_A) gen_a = lvl;
    if (k == KIND_EDGE_B) gen_b = lvl;
  endtask

  // Gray-code step: up goes 00 -> 01 -> 11 -> 10 (as A,B), down the reverse.
  task automatic queue_step(int dir);
    if ((dir > 0) == (gen_a == gen_b)) queue_item(KIND_EDGE_B, !gen_b, 0);
    else queue_item(KIND_EDGE_A, !gen_a, 0);
  endtask

  // Mostly inside a full turn either way, sometimes any 10-bit pattern.
  function automatic int pick_target();
    if ($urandom_range(0, 4) != 0) return int'($urandom_range(0, 720)) - 360;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  // Mostly runs of valid steps with ticks between them; the rest is bad
  // transitions, starts and unconstrained beats.
  task automatic queue_random(int n);
    int pick;
    int pin;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (run_left == 0) begin
          run_dir  = $urandom_range(0, 1) ? 1 : -1;
          run_left = $urandom_range(1, 12);
        end
        queue_step(run_dir);
        run_left--;
      end else if (pick < 75) begin
        queue_item(KIND_TICK, 1'($urandom_range(0, 1)), pick_target());
      end else if (pick < 80) begin
        queue_item(KIND_START, 1'($urandom_range(0, 1)), pick_target());
      end else if (pick < 88) begin
        // same level again on one pin: never a valid transition
        pin = $urandom_range(0, 1);
        if (pin != 0) queue_item(KIND_EDGE_B, gen_b, pick_target());
        else queue_item(KIND_EDGE_A, gen_a, pick_target());
      end else begin
        queue_item(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_target());
      end
    end
  endtask

  // Wait until every queued beat has gone in and its result has come back.
  task automatic drain();
    while (pending_beats.size() != 0 || results_seen < beats_offered) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MOTOR_MAX:  motor_top = val;
      REG_GEAR_MAX:   gear_top  = val;
      REG_PROP_GAIN:  kp_m      = val;
      REG_INTEG_GAIN: ki_m      = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] m, logic [15:0] g, logic [15:0] p, logic [15:0] i);
    write_reg(REG_MOTOR_MAX, m);
    write_reg(REG_GEAR_MAX, g);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: presents the next pending beat at the falling edge once the
  // previous one is gone, with random gaps between beats.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    enc_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        it = pending_beats.pop_front();
        beats_offered++;
        kind           <= it.kind;
        pin_level      <= it.lvl;
        target_degrees <= it.tgt;
        in_valid       <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted input beat: run the model and queue what the block must return.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      readings_due.push_back(next_reading(kind_t'(kind), pin_level, target_degrees));
      beat_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long park on request so the
  // block fills and holds off the sender.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (park_sink) begin
      park_sink = 1'b0;
      sink_hold = PARK_CYCLES;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      sink_hold = $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  // Result checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (readings_due.size() == 0) begin
        $error("result beat with no expectation pending");
        fails++;
      end else begin
        want = readings_due.pop_front();
        compare_field("motor_count", want.motor, motor_count);
        compare_field("gear_count", want.gear, gear_count);
        compare_field("fault_count", want.faults, fault_count);
        compare_field("gear_angle", want.angle, gear_angle);
        compare_field("drive", want.drv, drive);
      end
    end
  end

  // Watchdog: work outstanding but no beat moving on either channel.
  int unsigned dead_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_beats.size() == 0 && results_seen >= beats_offered)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
      if (dead_cycles >= STALL_LIMIT) begin
        $display("quadrature_decoder_pi_position_loop_top regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset register values: one step up, a tick, back to zero
    queue_step(1);
    queue_item(KIND_TICK, 1'b0, 45);
    queue_step(-1);
    drain();

    // zero maxima: counters pinned at zero, tick angle forced to zero
    write_reg(REG_MOTOR_MAX, 16'd0);
    write_reg(REG_GEAR_MAX, 16'd0);
    queue_step(1);
    queue_step(-1);
    queue_item(KIND_TICK, 1'b1, 100);
    queue_item(KIND_EDGE_A, gen_a, 0);
    drain();

    // tiny maxima, extreme gains: down from zero loads the max, up wraps,
    // target -512 needs more than one wrap of the error
    write_all(16'd3, 16'd5, 16'h7fff, 16'h8000);
    queue_step(-1);
    queue_item(KIND_TICK, 1'b0, 511);
    queue_item(KIND_TICK, 1'b1, -512);
    queue_step(1);
    queue_step(1);
    queue_step(1);
    queue_item(KIND_EDGE_B, gen_b, 0);
    queue_item(KIND_START, 1'b1, 200);
    queue_item(KIND_TICK, 1'b0, -360);
    queue_item(KIND_TICK, 1'b0, 360);
    queue_item(KIND_TICK, 1'b1, 0);
    drain();

    // gear maximum below the count: angle saturates, counting continues
    write_reg(REG_GEAR_MAX, 16'd1);
    write_reg(REG_PROP_GAIN, 16'h8000);
    write_reg(REG_INTEG_GAIN, 16'h7fff);
    queue_item(KIND_TICK, 1'b0, 0);
    queue_step(1);
    repeat (4) queue_step(-1);
    drain();

    // random phases; the sink parks for a long stretch in the first one
    write_all(16'd7, 16'd23, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 8)));
    park_sink = 1'b1;
    queue_random(120);
    drain();

    write_all(16'hffff, 16'hffff, 16'h7fff, 16'h7fff);
    queue_random(80);
    drain();

    write_all(16'd1, 16'd1, 16'h8000, 16'h8000);
    queue_random(80);
    drain();

    write_all(16'd0, 16'd3, 16'hffff, 16'd1);
    queue_random(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_all(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      if (ph == 3) quiet = 1'b1;
      queue_random(60);
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (readings_due.size() != 0) begin
      $error("%0d expected result beats never arrived", readings_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("quadrature_decoder_pi_position_loop_top regression: pass");
    end else begin
      $display("quadrature_decoder_pi_position_loop_top regression: fail");
    end
    $finish;
  end

endmodule

>>> quadrature_decoder_pi_position_loop_top.f
rtl/qdpi_pkg.sv
rtl/qdpi_div.sv
rtl/quadrature_decoder_pi_position_loop_top.sv
verif/quadrature_decoder_pi_position_loop_top_tb.sv
